// ===== rtl/core/mrw_pkg.sv =====
// Package for the Miller-Rabin witness round unit: widths and payload types.
// No dependencies.
`timescale 1ns / 1ps
package mrw_pkg;
  localparam int unsigned NumWidth = 64;
  localparam int unsigned CntWidth = $clog2(NumWidth + 1);

  typedef logic [NumWidth-1:0] num_t;

  // Classification of one transaction by the front part
  typedef struct packed {
    logic special;   // decided without exponentiation
    logic verdict;   // verdict for special items
    num_t n;
    num_t a;
  } job_t;

  typedef struct packed {
    logic probable_prime;
    logic special_case;
  } res_t;
endpackage

// ===== rtl/core/mrw_if.sv =====
// Valid/ready channel interfaces for the Miller-Rabin witness round unit.
// No dependencies.
`timescale 1ns / 1ps
interface mrw_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] candidate;
  logic [63:0] base;
  modport source (output valid, candidate, base, input ready);
  modport sink (input valid, candidate, base, output ready);
endinterface

interface mrw_out_if;
  logic valid;
  logic ready;
  logic probable_prime;
  logic special_case;
  modport source (output valid, probable_prime, special_case, input ready);
  modport sink (input valid, probable_prime, special_case, output ready);
endinterface

// ===== rtl/core/mrw_front.sv =====
// Front part: accepts transactions, classifies small and even candidates.
// Depends on mrw_pkg and mrw_if.
`timescale 1ns / 1ps
module mrw_front import mrw_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  mrw_in_if.sink       in_i,
  output logic         job_valid_o,
  input  logic         job_ready_i,
  output job_t         job_o
);
  // Two-entry queue toward the back part
  job_t             mem_q [2];
  logic             wr_q, rd_q;
  logic [1:0]       cnt_q;
  num_t             n, a;
  job_t             job;
  logic             push, pop;

  assign n = in_i.candidate[NumWidth-1:0];
  assign a = in_i.base[NumWidth-1:0];

  // Classification
  always_comb begin
    job.n = n;
    job.a = a;
    job.special = (n <= num_t'(3)) || !n[0];
    job.verdict = (n == num_t'(2)) || (n == num_t'(3));
  end

  assign in_i.ready  = (cnt_q != 2'd2);
  assign push        = in_i.valid && in_i.ready;
  assign job_valid_o = (cnt_q != 2'd0);
  assign pop         = job_valid_o && job_ready_i;
  assign job_o       = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= job;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ===== rtl/core/mrw_mulmod.sv =====
// Shift-add modular multiplier, one bit of y per cycle, MSB first.
// Depends on mrw_pkg.
`timescale 1ns / 1ps
module mrw_mulmod import mrw_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  num_t x_i,
  input  num_t y_i,
  input  num_t n_i,
  output logic done_o,
  output num_t p_o
);
  num_t                acc_q, acc_d, x_q, y_q, n_q;
  logic [CntWidth-1:0] cnt_q;
  logic                busy_q;
  logic [NumWidth:0]   dbl, dbl_r, sum;

  // acc = 2*acc mod n, then + x mod n when the current bit of y is set
  always_comb begin
    dbl   = {acc_q, 1'b0};
    dbl_r = (dbl >= {1'b0, n_q}) ? dbl - {1'b0, n_q} : dbl;
    sum   = dbl_r + {1'b0, x_q};
    if (y_q[NumWidth-1]) begin
      acc_d = (sum >= {1'b0, n_q}) ? num_t'(sum - {1'b0, n_q}) : num_t'(sum);
    end else begin
      acc_d = num_t'(dbl_r);
    end
  end

  assign p_o = acc_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      x_q   <= x_i;
      y_q   <= y_i;
      n_q   <= n_i;
    end else if (busy_q) begin
      acc_q <= acc_d;
      y_q   <= {y_q[NumWidth-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntWidth'(NumWidth - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== rtl/core/mrw_back.sv =====
// Back part: modular exponentiation and squaring loop, result register.
// Depends on mrw_pkg, mrw_if and mrw_mulmod.
`timescale 1ns / 1ps
module mrw_back import mrw_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     job_valid_i,
  output logic     job_ready_o,
  input  job_t     job_i,
  mrw_out_if.source out_o
);
  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StRedB  = 7'b0000010,
    StMulR  = 7'b0000100,
    StSqB   = 7'b0001000,
    StSqX   = 7'b0010000,
    StCheck = 7'b0100000,
    StOut   = 7'b1000000
  } state_e;

  state_e              state_q;
  num_t                n_q, nm1_q, b_q, r_q, e_q;
  logic [CntWidth-1:0] s_q;
  logic                pp_q, sc_q;
  logic                mm_start;
  num_t                mm_x, mm_y, mm_p;
  logic                mm_done;
  num_t                nm1_init;
  num_t                d_init;
  logic [CntWidth-1:0] s_init;

  // Split n-1 into d * 2^s: s is the index of the lowest set bit
  always_comb begin
    nm1_init = job_i.n - num_t'(1);
    s_init   = '0;
    for (int i = NumWidth - 1; i >= 0; i--) begin
      if (nm1_init[i]) s_init = CntWidth'(i);
    end
    d_init = nm1_init >> s_init;
  end

  mrw_mulmod u_mm (
    .clk_i, .rst_ni, .start_i(mm_start), .x_i(mm_x), .y_i(mm_y),
    .n_i(n_q), .done_o(mm_done), .p_o(mm_p)
  );

  assign job_ready_o          = (state_q == StIdle);
  assign out_o.valid          = (state_q == StOut);
  assign out_o.probable_prime = pp_q;
  assign out_o.special_case   = sc_q;

  // Multiplier launches on entry to each multiply state
  // (base reduction runs as 1 * a, so a may exceed n)
  always_comb begin
    mm_x = b_q;
    mm_y = num_t'(1);
    unique case (state_q)
      StRedB: begin mm_x = num_t'(1); mm_y = b_q; end
      StMulR: begin mm_x = r_q; mm_y = b_q; end
      StSqB:  begin mm_x = b_q; mm_y = b_q; end
      StSqX:  begin mm_x = r_q; mm_y = r_q; end
      default: ;
    endcase
  end

  logic go_q;
  assign mm_start = go_q;

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && job_valid_i) begin
      n_q   <= job_i.n;
      nm1_q <= nm1_init;
      b_q   <= job_i.a;
      r_q   <= num_t'(1);
      e_q   <= d_init;
      s_q   <= s_init;
      pp_q  <= job_i.verdict;
      sc_q  <= job_i.special;
    end else if (mm_done) begin
      unique case (state_q)
        StRedB, StSqB: begin
          b_q <= mm_p;
          if (state_q == StSqB) e_q <= e_q >> 1;
        end
        StMulR: r_q <= mm_p;
        StSqX: begin
          r_q  <= mm_p;
          s_q  <= s_q - 1'b1;
          // after a squaring only n-1 counts as prime
          pp_q <= (mm_p == nm1_q);
        end
        default: ;
      endcase
    end else if (state_q == StCheck) begin
      pp_q <= (r_q == num_t'(1)) || (r_q == nm1_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      go_q    <= 1'b0;
    end else begin
      go_q <= 1'b0;
      unique case (state_q)
        StIdle: if (job_valid_i) begin
          if (job_i.special) state_q <= StOut;
          else begin
            state_q <= StRedB;
            go_q    <= 1'b1;
          end
        end
        StRedB: if (mm_done) begin
          // e is odd and nonzero here
          state_q <= StMulR;
          go_q    <= 1'b1;
        end
        StMulR: if (mm_done) begin
          if ((e_q >> 1) == '0) state_q <= StCheck;
          else begin
            state_q <= StSqB;
            go_q    <= 1'b1;
          end
        end
        StSqB: if (mm_done) begin
          if (e_q[1]) begin
            state_q <= StMulR;
            go_q    <= 1'b1;
          end else begin
            state_q <= StSqB;
            go_q    <= 1'b1;
          end
        end
        StCheck: begin
          // x = a^d of 1 or n-1 decides at once
          if (r_q == nm1_q || r_q == num_t'(1)) state_q <= StOut;
          else if (s_q <= CntWidth'(1)) state_q <= StOut;
          else begin
            state_q <= StSqX;
            go_q    <= 1'b1;
          end
        end
        StSqX: if (mm_done) begin
          if (mm_p == num_t'(1) || mm_p == nm1_q) state_q <= StOut;
          else state_q <= StSqX;
          go_q <= !(mm_p == num_t'(1) || mm_p == nm1_q) && (s_q > CntWidth'(2));
          if (!(mm_p == num_t'(1) || mm_p == nm1_q) && (s_q <= CntWidth'(2)))
            state_q <= StOut;
        end
        StOut: if (out_o.ready) state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule

// ===== rtl/core/miller_rabin_witness_round_unit.sv =====
// Miller-Rabin witness round unit, top level: front classifier, queue, back engine.
// Small or even candidates are decided without exponentiation; otherwise each
// modular product runs on the bit-serial multiplier, up to 126 products.
// One item in the back engine at a time; the front queue holds two more.
// Reset is asynchronous, active low, and empties the queue and the engine.
`timescale 1ns / 1ps
module miller_rabin_witness_round_unit import mrw_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  mrw_in_if.sink     in_i,
  mrw_out_if.source  out_o
);
  logic job_valid, job_ready;
  job_t job;

  mrw_front u_front (
    .clk_i, .rst_ni, .in_i, .job_valid_o(job_valid), .job_ready_i(job_ready),
    .job_o(job)
  );

  mrw_back u_back (
    .clk_i, .rst_ni, .job_valid_i(job_valid), .job_ready_o(job_ready),
    .job_i(job), .out_o
  );
endmodule

// ===== rtl/core/mrw_checker.sv =====
// Port checker for the Miller-Rabin witness round unit, bound to the top level.
// Depends on no package or interface; the bind names the top level.
`timescale 1ns / 1ps
module mrw_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_pp_i,
  input logic out_sc_i
);
  // A held result keeps its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_pp_i) && $stable(out_sc_i))
    else $error("result changed while stalled");
  // Nothing comes out right after reset
  assert property (@(posedge clk_i) $rose(rst_ni) |-> !out_valid_i)
    else $error("result right after reset");
  // Input side is open right after reset
  assert property (@(posedge clk_i) $rose(rst_ni) |-> in_ready_i)
    else $error("input blocked after reset");
  // No result while reset is held
  assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("result during reset");
  // A stalled result stays valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped");
endmodule

bind miller_rabin_witness_round_unit mrw_checker u_mrw_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_ready_i(in_i.ready),
  .out_valid_i(out_o.valid), .out_ready_i(out_o.ready),
  .out_pp_i(out_o.probable_prime), .out_sc_i(out_o.special_case)
);
